// ===== sv/aps_pkg.sv =====
// Shared word types and constants for the amicable pair check unit.
package aps_pkg;

    localparam int FIELD_WIDTH   = 16;
    localparam int SUM_OUT_WIDTH = 20;
    localparam logic [SUM_OUT_WIDTH-1:0] SUM_OUT_MAX = {SUM_OUT_WIDTH{1'b1}};

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] first_number;
        logic [FIELD_WIDTH-1:0] second_number;
    } pair_word_t;

    typedef struct packed {
        logic                     is_amicable;
        logic [SUM_OUT_WIDTH-1:0] first_divisor_sum;
    } result_word_t;

endpackage

// ===== sv/aps_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module aps_div
    import aps_pkg::*;
#(
    parameter int NW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [NW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient,
    output logic [NW-1:0] remainder
);

    localparam int CW = $clog2(NW + 1);
    localparam logic [CW-1:0] LAST_BIT = CW'(NW - 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [NW-1:0] rem_reg, rem_next;
    logic [NW-1:0] dvs_reg, dvs_next;
    logic [NW:0]   trial;
    logic          fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[NW-1]};
        fits      = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = LAST_BIT;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NW-2:0], fits};
            rem_next = fits ? NW'(trial - {1'b0, dvs_reg}) : trial[NW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== sv/aps_aliq.sv =====
// Aliquot sum engine: trial divisors up to the square root, paired divisors.
module aps_aliq
    import aps_pkg::*;
#(
    parameter int NW = 16,
    parameter int SW = NW + 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] operand,
    output logic          done,
    output logic [SW-1:0] sum
);

    localparam logic [1:0] A_IDLE  = 2'd0;
    localparam logic [1:0] A_CHECK = 2'd1;
    localparam logic [1:0] A_DIV   = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] d_reg, d_next;
    logic [NW+1:0] sq_reg, sq_next;
    logic [SW-1:0] total_reg, total_next;
    logic          div_start;
    logic          div_done;
    logic [NW-1:0] div_quo;
    logic [NW-1:0] div_rem;
    logic          past_root;
    logic [NW-1:0] partner;

    aps_div #(.NW(NW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        past_root  = sq_reg > (NW+2)'(n_reg);
        partner    = (div_quo != d_reg) ? div_quo : '0;
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        total_next = total_reg;
        div_start  = 1'b0;
        case (state_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    n_next     = operand;
                    d_next     = NW'(1);
                    sq_next    = (NW+2)'(1);
                    total_next = '0;
                    state_next = A_CHECK;
                end
            end
            A_CHECK:
            begin
                if (past_root)
                begin
                    // a start on the done cycle begins the next pass at once
                    if (start)
                    begin
                        n_next     = operand;
                        d_next     = NW'(1);
                        sq_next    = (NW+2)'(1);
                        total_next = '0;
                    end
                    else
                    begin
                        state_next = A_IDLE;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = A_DIV;
                end
            end
            A_DIV:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        total_next = total_reg + SW'(d_reg) + SW'(partner);
                    end
                    sq_next    = sq_reg + (NW+2)'({d_reg, 1'b1});
                    d_next     = d_reg + 1'b1;
                    state_next = A_CHECK;
                end
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        total_reg <= total_next;
    end

    // divisor sum includes n itself
    assign done = (state_reg == A_CHECK) && past_root;
    assign sum  = total_reg - SW'(n_reg);

endmodule

// ===== sv/amicable_pair_check_unit.sv =====
// Top level: amicable pair test, sequencing two aliquot sums and the result word.
// Each pass over n runs the bit-serial divider once per trial divisor up to floor(sqrt(n)).
// The second pass runs only when the first sum matches the second number.
// One pair in flight; the next word is taken once the result is in the output register.
// Reset clears the sequencer, the divider control and the output valid; no memories.
module amicable_pair_check_unit
    import aps_pkg::*;
#(
    parameter int NUMBER_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         pair_valid,
    output logic         pair_stall,
    input  pair_word_t   pair,
    output logic         result_valid,
    input  logic         result_stall,
    output result_word_t result
);

    localparam int NW = NUMBER_WIDTH;
    localparam int SW = NW + 4;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PASS1 = 2'd1;
    localparam logic [1:0] ST_PASS2 = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [NW-1:0] a_reg, a_next;
    logic [NW-1:0] b_reg, b_next;
    logic [SW-1:0] sum1_reg, sum1_next;
    logic          amic_reg, amic_next;
    logic          out_valid_reg, out_valid_next;
    result_word_t  out_reg, out_next;
    logic [31:0]   first_wide;
    logic [31:0]   second_wide;
    logic [NW-1:0] first_masked;
    logic [NW-1:0] second_masked;
    logic          aliq_start;
    logic [NW-1:0] aliq_operand;
    logic          aliq_done;
    logic [SW-1:0] aliq_sum;
    logic [39:0]   sum1_wide;
    logic          load_out;

    aps_aliq #(.NW(NW), .SW(SW)) u_aliq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (aliq_start),
        .operand (aliq_operand),
        .done    (aliq_done),
        .sum     (aliq_sum)
    );

    assign first_wide    = 32'(pair.first_number);
    assign second_wide   = 32'(pair.second_number);
    assign first_masked  = first_wide[NW-1:0];
    assign second_masked = second_wide[NW-1:0];
    assign sum1_wide     = 40'(sum1_reg);
    assign pair_stall    = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        sum1_next      = sum1_reg;
        amic_next      = amic_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        aliq_start     = 1'b0;
        aliq_operand   = first_masked;
        load_out       = 1'b0;
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (pair_valid)
                begin
                    a_next     = first_masked;
                    b_next     = second_masked;
                    aliq_start = 1'b1;
                    state_next = ST_PASS1;
                end
            end
            ST_PASS1:
            begin
                if (aliq_done)
                begin
                    sum1_next = aliq_sum;
                    if (aliq_sum == SW'(b_reg))
                    begin
                        aliq_start   = 1'b1;
                        aliq_operand = b_reg;
                        state_next   = ST_PASS2;
                    end
                    else
                    begin
                        amic_next  = 1'b0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_PASS2:
            begin
                if (aliq_done)
                begin
                    amic_next  = (aliq_sum == SW'(a_reg));
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    load_out = 1'b1;
                    out_next.is_amicable = amic_reg;
                    out_next.first_divisor_sum = (sum1_wide > 40'(SUM_OUT_MAX)) ?
                        SUM_OUT_MAX : sum1_wide[SUM_OUT_WIDTH-1:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        sum1_reg <= sum1_next;
        amic_reg <= amic_next;
        out_reg  <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_done_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        aliq_done |-> (state_reg == ST_PASS1 || state_reg == ST_PASS2))
        else $error("aliquot done outside a pass");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (pair_valid && !pair_stall) |=> (state_reg == ST_PASS1))
        else $error("accepted word did not start first pass");

    a_pass2_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PASS2) |-> (sum1_reg == SW'(b_reg)))
        else $error("second pass without first sum match");

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (result_valid && state_reg == ST_IDLE))
        else $error("result load did not present word");

endmodule

// ===== sim/amicable_pair_monitor.sv =====
`timescale 1ns / 100ps
// Monitor for the amicable pair check unit: predicts each result word and compares it.
module amicable_pair_monitor
    import aps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         pair_valid,
    input  logic         pair_stall,
    input  pair_word_t   pair,
    input  logic         result_valid,
    input  logic         result_stall,
    input  result_word_t result,
    output int           mismatches,
    output int           outstanding
);

    result_word_t predicted_results[$];
    result_word_t predicted;
    int unsigned  first_total;

    function automatic int unsigned proper_divisor_total(input logic [FIELD_WIDTH-1:0] n);
        int unsigned value;
        int unsigned total;
        int unsigned d;
        value = n;
        total = 0;
        for (d = 1; d <= value / 2; d++)
        begin
            if (value % d == 0)
                total += d;
        end
        return total;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            predicted_results.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("unexpected result word: is_amicable %0d first_divisor_sum %0d",
                           result.is_amicable, result.first_divisor_sum);
                    mismatches++;
                end
                else
                begin
                    predicted = predicted_results.pop_front();
                    if (result.is_amicable !== predicted.is_amicable)
                    begin
                        $error("is_amicable: expected %0d, got %0d",
                               predicted.is_amicable, result.is_amicable);
                        mismatches++;
                    end
                    if (result.first_divisor_sum !== predicted.first_divisor_sum)
                    begin
                        $error("first_divisor_sum: expected %0d, got %0d",
                               predicted.first_divisor_sum, result.first_divisor_sum);
                        mismatches++;
                    end
                end
            end
            if (pair_valid && !pair_stall)
            begin
                first_total = proper_divisor_total(pair.first_number);
                predicted.is_amicable = (first_total == pair.second_number) &&
                    (proper_divisor_total(pair.second_number) == pair.first_number);
                predicted.first_divisor_sum = (first_total > SUM_OUT_MAX) ? SUM_OUT_MAX :
                                              first_total[SUM_OUT_WIDTH-1:0];
                predicted_results.push_back(predicted);
            end
            outstanding = predicted_results.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top: clock, reset, pair stimulus, result back-pressure and the verdict.
module tb_top;
    import aps_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int CYCLE_LIMIT    = 5_000_000;
    localparam int HOLD_CYCLES    = 2500;
    localparam int DRAIN_CYCLES   = 200;
    localparam int DIRECTED_COUNT = 23;
    localparam int PHASE_ITEMS    = 18;
    localparam int PRESSURE_ITEMS = 8;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         pair_valid;
    logic         pair_stall;
    pair_word_t   pair;
    logic         result_valid;
    logic         result_stall;
    result_word_t result;

    int   mismatches;
    int   outstanding;
    int   cycle_count = 0;
    int   sender_idle_pct = 0;
    int   receiver_stall_pct = 0;
    logic hold_request = 1'b0;
    logic hold_done = 1'b0;
    logic pair_taken;

    amicable_pair_check_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_valid   (pair_valid),
        .pair_stall   (pair_stall),
        .pair         (pair),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    amicable_pair_monitor u_monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_valid   (pair_valid),
        .pair_stall   (pair_stall),
        .pair         (pair),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pair_taken <= 1'b0;
        else
            pair_taken <= pair_valid && !pair_stall;
    end

    // result side: random stall, plus one long hold-off when requested
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            result_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    function automatic pair_word_t friendly_pair(input int idx);
        pair_word_t word;
        case (idx)
            0:       word = {16'd220,   16'd284};
            1:       word = {16'd1184,  16'd1210};
            2:       word = {16'd2620,  16'd2924};
            3:       word = {16'd5020,  16'd5564};
            4:       word = {16'd6232,  16'd6368};
            5:       word = {16'd10744, 16'd10856};
            6:       word = {16'd12285, 16'd14595};
            7:       word = {16'd17296, 16'd18416};
            8:       word = {16'd6,     16'd6};
            9:       word = {16'd28,    16'd28};
            10:      word = {16'd496,   16'd496};
            default: word = {16'd8128,  16'd8128};
        endcase
        return word;
    endfunction

    function automatic pair_word_t directed_pair(input int idx);
        pair_word_t word;
        case (idx)
            0:       word = {16'd0,     16'd0};
            1:       word = {16'd1,     16'd0};
            2:       word = {16'd0,     16'd1};
            3:       word = {16'd1,     16'd1};
            4:       word = {16'd2,     16'd1};
            5:       word = {16'd12,    16'd16};
            6:       word = {16'd6,     16'd6};
            7:       word = {16'd28,    16'd28};
            8:       word = {16'd496,   16'd496};
            9:       word = {16'd8128,  16'd8128};
            10:      word = {16'd220,   16'd284};
            11:      word = {16'd284,   16'd220};
            12:      word = {16'd17296, 16'd18416};
            13:      word = {16'd18416, 16'd17296};
            14:      word = {16'd65535, 16'd65535};
            15:      word = {16'd65535, 16'd45921};
            16:      word = {16'd65521, 16'd1};
            17:      word = {16'd65520, 16'd0};
            18:      word = {16'd32768, 16'd32767};
            19:      word = {16'd0,     16'd65535};
            20:      word = {16'd43690, 16'd21845};
            21:      word = {16'd21845, 16'd43690};
            default: word = {16'd12285, 16'd14595};
        endcase
        return word;
    endfunction

    // mostly pairs that pass the first sum test, so the second pass runs
    function automatic pair_word_t random_pair();
        int         kind;
        int         k;
        pair_word_t word;
        kind = $urandom_range(0, 99);
        if (kind < 25)
        begin
            k = $urandom_range(0, 15);
            word.first_number  = 16'(1 << k);
            word.second_number = word.first_number - 16'd1;
        end
        else if (kind < 45)
        begin
            k = $urandom_range(0, 13);
            word.first_number  = 16'(3 << k);
            word.second_number = 16'((5 << k) - 4);
        end
        else if (kind < 60)
        begin
            word = friendly_pair($urandom_range(0, 11));
            if ($urandom_range(0, 1) == 1)
                word = {word.second_number, word.first_number};
        end
        else if (kind < 80)
        begin
            word.first_number  = 16'($urandom_range(0, 2047));
            word.second_number = 16'($urandom_range(0, 2047));
        end
        else
            word = pair_word_t'($urandom);
        return word;
    endfunction

    task automatic send_pair(input pair_word_t word);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            pair_valid <= 1'b0;
            @(negedge clk);
        end
        pair <= word;
        pair_valid <= 1'b1;
        do
            @(negedge clk);
        while (!pair_taken);
    endtask

    initial
    begin
        int         i;
        int         phase;
        pair_word_t word;
        rst_n = 1'b0;
        pair_valid = 1'b0;
        pair = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < DIRECTED_COUNT; i++)
            send_pair(directed_pair(i));

        for (phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = (phase == 1) ? 55 : (phase == 3) ? 35 : 0;
            receiver_stall_pct <= (phase == 2) ? 55 : (phase == 3) ? 35 : 0;
            for (i = 0; i < PHASE_ITEMS; i++)
                send_pair(random_pair());
        end

        // long result hold-off while pairs keep coming
        sender_idle_pct = 0;
        receiver_stall_pct <= 0;
        hold_request <= 1'b1;
        for (i = 0; i < PRESSURE_ITEMS; i++)
        begin
            word.first_number  = 16'($urandom_range(0, 255));
            word.second_number = 16'($urandom_range(0, 255));
            send_pair(word);
        end

        pair_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
